FILE: design/punf_pkg.sv
// shared types, codes and the paeth predictor for the scanline unfilter
package punf_pkg;

   localparam logic [7:0] FILTER_NONE  = 8'd0;
   localparam logic [7:0] FILTER_SUB   = 8'd1;
   localparam logic [7:0] FILTER_UP    = 8'd2;
   localparam logic [7:0] FILTER_AVG   = 8'd3;
   localparam logic [7:0] FILTER_PAETH = 8'd4;

   localparam logic CSR_BYTES_PER_PIXEL = 1'b0;
   localparam logic CSR_ROW_BYTES       = 1'b1;

   localparam int CSR_DATA_WIDTH = 14;

   typedef struct packed {
      logic [7:0] data;
      logic       is_type;
      logic [7:0] ftype;
      logic       first_row;
      logic       last;
   } punf_item_type;

   function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      logic [10:0] pa;
      logic [10:0] pb;
      logic [10:0] pc;
      da = $signed({3'b000, b}) - $signed({3'b000, c});
      db = $signed({3'b000, a}) - $signed({3'b000, c});
      dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
      pa = da[10] ? 11'(-da) : 11'(da);
      pb = db[10] ? 11'(-db) : 11'(db);
      pc = dc[10] ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end else begin
         return c;
      end
   endfunction

endpackage

FILE: design/png_scanline_unfilter.sv
// PNG scanline unfilter top level: filtered bytes in, reconstructed bytes out.
// Every accepted byte, type bytes included, passes the stage one register, so the
// block sustains one byte per clock while rsp_stall is low; a data byte then moves
// on to the result register, and rsp_stall can hold it in stage one. The pace is
// set by the line store, read once and written once per data byte, and by the left
// history, whose byte one pixel back feeds the next byte's Sub, Average and Paeth
// predictors. The line store has no reset; an image's first row reads it as zero.
module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_image_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_recon_byte,
   output logic                                rsp_last_in_row,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [punf_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import punf_pkg::*;

   localparam int CW = $clog2(MAX_ROW_BYTES + 1);
   localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

   logic [3:0] bpp_ff;
   logic [CSR_DATA_WIDTH-1:0] row_ff;
   logic advance;
   logic s1_valid;
   punf_item_type s1_item;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] s1_addr_ff;
   logic rd_en;
   logic [7:0] rd_data;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= 4'd1;
         row_ff <= CSR_DATA_WIDTH'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff <= csr_write_data[3:0];
            CSR_ROW_BYTES:       row_ff <= csr_write_data;
            default:             row_ff <= row_ff;
         endcase
      end
   end

   // column of the byte in stage one, kept for its write back
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_addr_ff <= rd_addr;
      end
   end

   punf_ctrl #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES),
      .CW(CW),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_image_start(req_image_start),
      .row_bytes(row_ff),
      .advance(advance),
      .s1_valid(s1_valid),
      .s1_item(s1_item),
      .rd_addr(rd_addr),
      .rd_en(rd_en)
   );

   punf_line_store #(
      .DEPTH(MAX_ROW_BYTES),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   punf_recon #(
      .AW(AW)
   ) u_recon (
      .clock(clock),
      .reset(reset),
      .bytes_per_pixel(bpp_ff),
      .s1_valid(s1_valid),
      .s1_item(s1_item),
      .s1_addr(s1_addr_ff),
      .rd_data(rd_data),
      .advance(advance),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_recon_byte(rsp_recon_byte),
      .rsp_last_in_row(rsp_last_in_row)
   );

endmodule

FILE: design/punf_line_store.sv
// prior row line store, one write and one registered read port
module punf_line_store #(
   parameter int DEPTH = 8192,
   parameter int AW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // a column is never read in the cycle its own previous value is written back
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && rd_addr == wr_addr))
      else $error("line store read and write hit the same entry");

endmodule

FILE: design/punf_ctrl.sv
// row sequencing, line store read issue and the stage one item register
module punf_ctrl #(
   parameter int MAX_ROW_BYTES = 8192,
   parameter int CW = 14,
   parameter int AW = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_image_start,
   input  logic [punf_pkg::CSR_DATA_WIDTH-1:0] row_bytes,
   input  logic                             advance,
   output logic                             s1_valid,
   output punf_pkg::punf_item_type          s1_item,
   output logic [AW-1:0]                    rd_addr,
   output logic                             rd_en
);
   import punf_pkg::*;

   logic [CW-1:0] column_ff, column_in;
   logic [7:0] ftype_ff, ftype_in;
   logic first_ff, first_in;
   logic s1_valid_ff, s1_valid_in;
   punf_item_type item_ff, item_in;
   logic [CW-1:0] row_eff;
   logic [CW-1:0] col_cur;
   logic first_cur;
   logic accept;

   always_comb begin
      if (row_bytes == '0) begin
         row_eff = CW'(1);
      end else if (32'(row_bytes) > MAX_ROW_BYTES) begin
         row_eff = CW'(MAX_ROW_BYTES);
      end else begin
         row_eff = CW'(row_bytes);
      end
   end

   assign req_stall = s1_valid_ff && !advance;
   assign accept = req_valid && !req_stall;

   always_comb begin
      col_cur = req_image_start ? '0 : column_ff;
      first_cur = req_image_start ? 1'b1 : first_ff;
      column_in = column_ff;
      ftype_in = ftype_ff;
      first_in = first_ff;
      item_in.data = req_data_byte;
      item_in.first_row = first_cur;
      item_in.ftype = ftype_ff;
      item_in.is_type = (col_cur == '0);
      item_in.last = 1'b0;
      rd_addr = AW'(col_cur - CW'(1));
      rd_en = 1'b0;
      if (accept) begin
         first_in = first_cur;
         if (col_cur == '0) begin
            ftype_in = req_data_byte;
            column_in = CW'(1);
         end else begin
            rd_en = 1'b1;
            if (col_cur >= row_eff) begin
               item_in.last = 1'b1;
               column_in = '0;
               first_in = 1'b0;
            end else begin
               column_in = col_cur + CW'(1);
            end
         end
      end
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         ftype_ff <= FILTER_NONE;
         first_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff <= column_in;
         ftype_ff <= ftype_in;
         first_ff <= first_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item = item_ff;

   a_row_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      accept && rd_en && item_in.last |=> column_ff == '0 && !first_ff)
      else $error("row end did not return to the filter type byte");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(item_ff))
      else $error("stage one item lost while blocked");

endmodule

FILE: design/punf_recon.sv
// byte reconstruction, neighbor histories, write back and result register
module punf_recon #(
   parameter int AW = 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [3:0]              bytes_per_pixel,
   input  logic                    s1_valid,
   input  punf_pkg::punf_item_type s1_item,
   input  logic [AW-1:0]           s1_addr,
   input  logic [7:0]              rd_data,
   output logic                    advance,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [7:0]              wr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_recon_byte,
   output logic                    rsp_last_in_row
);
   import punf_pkg::*;

   logic [63:0] left_ff, left_in;
   logic [63:0] upleft_ff, upleft_in;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic out_last_ff;
   logic [2:0] sel;
   logic [7:0] a, b, c, r;
   logic [8:0] avg_sum;
   logic out_free;

   always_comb begin
      if (bytes_per_pixel == 4'd0) begin
         sel = 3'd0;
      end else if (bytes_per_pixel > 4'd8) begin
         sel = 3'd7;
      end else begin
         sel = 3'(bytes_per_pixel - 4'd1);
      end
   end

   assign a = left_ff[{sel, 3'b000} +: 8];
   assign c = upleft_ff[{sel, 3'b000} +: 8];
   assign b = s1_item.first_row ? 8'd0 : rd_data;
   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s1_item.ftype)
         FILTER_SUB:   r = s1_item.data + a;
         FILTER_UP:    r = s1_item.data + b;
         FILTER_AVG:   r = s1_item.data + avg_sum[8:1];
         FILTER_PAETH: r = s1_item.data + paeth_pred(a, b, c);
         default:      r = s1_item.data;
      endcase
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance = s1_valid && (s1_item.is_type || out_free);
   assign wr_en = advance && !s1_item.is_type;
   assign wr_addr = s1_addr;
   assign wr_data = r;

   always_comb begin
      left_in = left_ff;
      upleft_in = upleft_ff;
      if (advance) begin
         if (s1_item.is_type) begin
            left_in = '0;
            upleft_in = '0;
         end else begin
            left_in = {left_ff[55:0], r};
            upleft_in = {upleft_ff[55:0], b};
         end
      end
      if (wr_en) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         upleft_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff <= left_in;
         upleft_ff <= upleft_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         out_byte_ff <= r;
         out_last_ff <= s1_item.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_recon_byte = out_byte_ff;
   assign rsp_last_in_row = out_last_ff;

   // a data byte only leaves stage one when the result register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !out_valid_ff || !rsp_stall)
      else $error("pending result overwritten");

endmodule

FILE: verif/png_scanline_unfilter_test.sv
// testbench for the png scanline unfilter: scoreboard class, stimulus tasks and top module

localparam int ROW_LIMIT = 8192;

typedef struct packed {
   logic [7:0] recon_byte;
   logic       last_in_row;
} recon_result_type;

class unfilter_scoreboard;
   logic [3:0]       bpp_reg;
   logic [13:0]      row_reg;
   logic [7:0]       line_mem [ROW_LIMIT];
   logic [63:0]      left_hist;
   logic [63:0]      upleft_hist;
   int unsigned      column;
   logic [7:0]       row_type;
   bit               first_row;
   recon_result_type expected_pixels [$];
   int               fail_count;

   function new();
      bpp_reg     = 4'd1;
      row_reg     = 14'd1;
      left_hist   = '0;
      upleft_hist = '0;
      column      = 0;
      row_type    = '0;
      first_row   = 1'b1;
      fail_count  = 0;
   endfunction

   function void write_reg(logic index, logic [13:0] value);
      if (index == punf_pkg::CSR_BYTES_PER_PIXEL) begin
         bpp_reg = value[3:0];
      end else begin
         row_reg = value;
      end
   endfunction

   function int eff_bpp();
      if (bpp_reg == 4'd0) return 1;
      if (bpp_reg > 4'd8) return 8;
      return int'(bpp_reg);
   endfunction

   function int eff_row();
      if (row_reg == 14'd0) return 1;
      if (int'(row_reg) > ROW_LIMIT) return ROW_LIMIT;
      return int'(row_reg);
   endfunction

   function bit at_row_start();
      return column == 0;
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction

   function logic [7:0] pick_paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int p;
      int pa;
      int pb;
      int pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
      pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
      pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   // predicts the reconstructed byte for every accepted data byte; type bytes set the row filter
   function void note_byte(logic [7:0] x, logic start);
      int               idx;
      int               shift;
      logic [7:0]       a;
      logic [7:0]       b;
      logic [7:0]       c;
      logic [7:0]       r;
      logic [8:0]       sum;
      recon_result_type res;
      shift = 8 * (eff_bpp() - 1);
      if (start) begin
         first_row = 1'b1;
         column    = 0;
      end
      if (column == 0) begin
         row_type    = x;
         left_hist   = '0;
         upleft_hist = '0;
         column      = 1;
         return;
      end
      idx = int'(column) - 1;
      if (idx >= ROW_LIMIT) idx = ROW_LIMIT - 1;
      b = first_row ? 8'd0 : line_mem[idx];
      a = left_hist[shift +: 8];
      c = upleft_hist[shift +: 8];
      case (row_type)
         punf_pkg::FILTER_SUB: begin
            r = x + a;
         end
         punf_pkg::FILTER_UP: begin
            r = x + b;
         end
         punf_pkg::FILTER_AVG: begin
            sum = {1'b0, a} + {1'b0, b};
            r   = x + sum[8:1];
         end
         punf_pkg::FILTER_PAETH: begin
            r = x + pick_paeth(a, b, c);
         end
         default: begin
            r = x;
         end
      endcase
      line_mem[idx] = r;
      left_hist     = {left_hist[55:0], r};
      upleft_hist   = {upleft_hist[55:0], b};
      res.recon_byte  = r;
      res.last_in_row = (idx + 1 >= eff_row());
      if (res.last_in_row) begin
         column    = 0;
         first_row = 1'b0;
      end else begin
         column = idx + 2;
      end
      expected_pixels.push_back(res);
   endfunction

   function void report(string field, int want, int got);
      fail_count++;
      if (fail_count <= 100) $error("%s expected %0d actual %0d", field, want, got);
   endfunction

   function void check_pixel(logic [7:0] recon, logic last);
      recon_result_type want;
      if (expected_pixels.size() == 0) begin
         fail_count++;
         if (fail_count <= 100) $error("result transfer with nothing expected: %0d", recon);
         return;
      end
      want = expected_pixels.pop_front();
      if (recon !== want.recon_byte) report("recon_byte", want.recon_byte, recon);
      if (last !== want.last_in_row) report("last_in_row", want.last_in_row, last);
   endfunction
endclass

module png_scanline_unfilter_test;
   import punf_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam logic [7:0] FILTER_UNKNOWN = 8'd200;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_data_byte = '0;
   logic                      req_image_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_recon_byte;
   logic                      rsp_last_in_row;
   logic                      csr_write_enable = 1'b0;
   logic                      csr_index = 1'b0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   unfilter_scoreboard sb = new();
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 stuck_cycles = 0;

   logic [7:0]  known_filters [5] = '{FILTER_NONE, FILTER_SUB, FILTER_UP, FILTER_AVG,
                                      FILTER_PAETH};
   logic [3:0]  bpp_plan [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd7};
   logic [13:0] row_plan [6] = '{14'd1, 14'd30, 14'd5, 14'd0, 14'd2, 14'd12};
   int          send_plan [4] = '{0, 75, 0, 6};
   int          recv_plan [4] = '{0, 0, 75, 6};

   png_scanline_unfilter #(
      .MAX_ROW_BYTES(ROW_LIMIT)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_recon_byte  (rsp_recon_byte),
      .rsp_last_in_row (rsp_last_in_row),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // result check and watchdog count
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            sb.check_pixel(rsp_recon_byte, rsp_last_in_row);
         end
         if ((rsp_valid === 1'b1 && rsp_stall == 1'b0) ||
             (req_valid && req_stall === 1'b0)) begin
            stuck_cycles <= 0;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      wait (stuck_cycles >= STALL_LIMIT);
      $display("png_scanline_unfilter: mismatch");
      $finish;
   end

   function automatic logic [7:0] pick_filter();
      if ($urandom_range(7) != 0) return known_filters[$urandom_range(4)];
      return 8'($urandom_range(255, 5));
   endfunction

   task automatic send_byte(logic [7:0] data, logic start);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_image_start <= start;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(data, start);
   endtask

   // drop valid, drain expected results, then let the pipeline settle
   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [3:0] bpp, logic [13:0] rb);
      logic [13:0] bpp_word;
      bpp_word = {10'($urandom), bpp};
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BYTES_PER_PIXEL;
      csr_write_data   <= bpp_word;
      @(negedge clock);
      csr_index        <= CSR_ROW_BYTES;
      csr_write_data   <= rb;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(CSR_BYTES_PER_PIXEL, bpp_word);
      sb.write_reg(CSR_ROW_BYTES, rb);
   endtask

   task automatic run_phase(logic [3:0] bpp, logic [13:0] rb, int send_pct, int recv_pct,
                            int count);
      int         old_row;
      bit         fresh;
      bit         short_rows;
      logic [7:0] data;
      logic       start;
      old_row = sb.eff_row();
      configure(bpp, rb);
      // a longer row would read unwritten line store entries, so open a new image
      fresh          = sb.eff_row() > old_row;
      short_rows     = sb.eff_row() <= 64;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int n = 0; n < count; n++) begin
         if (n == 0 && fresh) begin
            start = 1'b1;
            data  = pick_filter();
         end else if (sb.at_row_start()) begin
            start = short_rows && ($urandom_range(7) == 0);
            data  = pick_filter();
         end else begin
            start = short_rows && ($urandom_range(149) == 0);
            data  = start ? pick_filter() : 8'($urandom);
         end
         send_byte(data, start);
      end
      finish_phase();
   endtask

   initial begin
      logic [3:0]  bpp;
      logic [13:0] rb;
      logic [7:0]  dir_types [6];
      dir_types = '{FILTER_NONE, FILTER_SUB, FILTER_UP, FILTER_AVG, FILTER_PAETH,
                    FILTER_UNKNOWN};
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: one byte rows
      send_byte(FILTER_PAETH, 1'b1);
      send_byte(8'hFF, 1'b0);
      finish_phase();

      // every filter type on a short image, extreme bytes
      configure(4'd1, 14'd3);
      for (int r = 0; r < 6; r++) begin
         send_byte(dir_types[r], r == 0);
         send_byte(8'hFF, 1'b0);
         send_byte(8'h00, 1'b0);
         send_byte(8'(8'h37 * (r + 1)), 1'b0);
      end
      finish_phase();

      for (int p = 0; p < 12; p++) begin
         if (p < 6) begin
            bpp = bpp_plan[p];
            rb  = row_plan[p];
         end else begin
            bpp = 4'($urandom);
            rb  = ($urandom_range(9) == 0) ? 14'd0 : 14'($urandom_range(24, 1));
         end
         run_phase(bpp, rb, send_plan[p % 4], recv_plan[p % 4], 110);
      end

      repeat (8) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("png_scanline_unfilter: match");
      end else begin
         $display("png_scanline_unfilter: mismatch");
      end
      $finish;
   end

endmodule
